FILE: hdl/u2c_pkg.sv
// Shared types, constants and the code point mapping for the UTF-8 to
// Windows-1251 transcoder. No dependencies.
package u2c_pkg;

  // byte classes
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] Lead2Mask   = 8'hE0;
  localparam logic [7:0] Lead2Code   = 8'hC0;
  localparam logic [7:0] Lead3Mask   = 8'hF0;
  localparam logic [7:0] Lead3Code   = 8'hE0;

  // pending continuation counts
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  // code points of interest
  localparam logic [15:0] CpCyrLow   = 16'h0410;
  localparam logic [15:0] CpCyrHigh  = 16'h044F;
  localparam logic [15:0] CpIo       = 16'h0401;
  localparam logic [15:0] CpIoSmall  = 16'h0451;
  localparam logic [15:0] CpEmDash   = 16'h2014;
  localparam logic [15:0] CpEnDash   = 16'h2013;
  localparam logic [15:0] CpLeftGuil = 16'h00AB;
  localparam logic [15:0] CpRightGuil = 16'h00BB;
  localparam logic [15:0] CpArrow    = 16'h2192;

  // output bytes
  localparam logic [7:0] CyrOffset = 8'hB0;  // 0xC0 - 0x10 modulo 256
  localparam logic [7:0] ByteIo     = 8'hA8;
  localparam logic [7:0] ByteIoSmall = 8'hB8;
  localparam logic [7:0] ByteDash   = 8'h2D;
  localparam logic [7:0] ByteQuote  = 8'h22;
  localparam logic [7:0] ByteArrow  = 8'h3E;
  localparam logic [7:0] ByteUnknown = 8'h3F;
  localparam logic [7:0] ByteTerm   = 8'h00;

  // sequence state carried between bytes
  typedef struct packed {
    logic [1:0] pending;
    logic       three;
    logic [4:0] lead;
    logic [7:0] middle;
  } seq_t;

  localparam seq_t SeqClear = '{pending: PendNone, three: 1'b0, lead: 5'd0, middle: 8'd0};

  // what one request produces
  typedef struct packed {
    logic       char_v;
    logic [7:0] char_byte;
    logic       term;
  } step_res_t;

  // one result in the output queue
  typedef struct packed {
    logic [7:0] byte_val;
    logic       eos;
  } res_t;

  function automatic logic [7:0] map_cp(input logic [15:0] cp);
    logic [7:0] r;
    if (cp >= CpCyrLow && cp <= CpCyrHigh) begin
      r = cp[7:0] + CyrOffset;
    end else if (cp == CpIo) begin
      r = ByteIo;
    end else if (cp == CpIoSmall) begin
      r = ByteIoSmall;
    end else if (cp == CpEmDash || cp == CpEnDash) begin
      r = ByteDash;
    end else if (cp == CpLeftGuil || cp == CpRightGuil) begin
      r = ByteQuote;
    end else if (cp == CpArrow) begin
      r = ByteArrow;
    end else begin
      r = ByteUnknown;
    end
    return r;
  endfunction

endpackage

FILE: hdl/u2c_step.sv
// Per-byte decode: next sequence state and results for one request.
// Depends on u2c_pkg.
module u2c_step (
  input  logic [7:0]        byte_i,
  input  u2c_pkg::seq_t     seq_i,
  input  logic              room_i,
  output u2c_pkg::seq_t     seq_o,
  output u2c_pkg::step_res_t res_o
);

  logic [15:0] cp;

  // assemble the code point from lead, middle and this byte
  always_comb begin
    if (seq_i.three) begin
      cp = {seq_i.lead[3:0], seq_i.middle[5:0], byte_i[5:0]};
    end else begin
      cp = {5'd0, seq_i.lead, byte_i[5:0]};
    end
  end

  // byte handling
  always_comb begin
    seq_o           = seq_i;
    res_o.char_v    = 1'b0;
    res_o.char_byte = byte_i;
    res_o.term      = 1'b0;
    priority if (byte_i == u2c_pkg::ByteTerm) begin
      // terminator, with a lone middle byte of a cut three-byte sequence replayed
      res_o.char_v    = (seq_i.pending == u2c_pkg::PendOne) && seq_i.three &&
                        (seq_i.middle != 8'd0) && (seq_i.middle < u2c_pkg::AsciiLimit) &&
                        room_i;
      res_o.char_byte = seq_i.middle;
      res_o.term      = 1'b1;
      seq_o           = u2c_pkg::SeqClear;
    end else if (seq_i.pending != u2c_pkg::PendNone) begin
      if (seq_i.three && seq_i.pending == u2c_pkg::PendTwo) begin
        seq_o.middle  = byte_i;
        seq_o.pending = u2c_pkg::PendOne;
      end else begin
        seq_o           = u2c_pkg::SeqClear;
        res_o.char_v    = room_i;
        res_o.char_byte = u2c_pkg::map_cp(cp);
      end
    end else if (room_i) begin
      priority if (byte_i < u2c_pkg::AsciiLimit) begin
        res_o.char_v = 1'b1;
      end else if ((byte_i & u2c_pkg::Lead2Mask) == u2c_pkg::Lead2Code) begin
        seq_o.lead    = byte_i[4:0];
        seq_o.three   = 1'b0;
        seq_o.pending = u2c_pkg::PendOne;
      end else if ((byte_i & u2c_pkg::Lead3Mask) == u2c_pkg::Lead3Code) begin
        seq_o.lead    = {1'b0, byte_i[3:0]};
        seq_o.three   = 1'b1;
        seq_o.pending = u2c_pkg::PendTwo;
      end else begin
        seq_o = seq_i;  // stray byte dropped
      end
    end else begin
      seq_o = seq_i;  // no room, byte ignored
    end
  end

endmodule

FILE: hdl/u2c_resq.sv
// Four-entry result queue, up to two pushes and one pop per cycle.
// Depends on u2c_pkg.
module u2c_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push0_i,
  input  logic           push1_i,
  input  u2c_pkg::res_t  data0_i,
  input  u2c_pkg::res_t  data1_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output u2c_pkg::res_t  data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  u2c_pkg::res_t     mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [PtrW:0]     count_q, count_d;
  logic [1:0]        n_push;
  logic              do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign n_push  = {1'b0, push0_i} + {1'b0, push1_i};
  assign wr_ptr1 = wr_ptr_q + PtrW'(1);

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
    count_d  = count_q + (PtrW+1)'(n_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage; second push lands behind the first
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      if (push0_i) begin
        mem_q[wr_ptr1] <= data1_i;
      end else begin
        mem_q[wr_ptr_q] <= data1_i;
      end
    end
  end

  // keep room for two results of the next request
  assign full_o  = count_q > (PtrW+1)'(Depth - 2);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

FILE: hdl/utf8_to_cp1251_transcoder.sv
// Top level of the UTF-8 to Windows-1251 transcoder: capacity register,
// sequence state, emitted count. Depends on u2c_pkg, u2c_step, u2c_resq.
//
//  port group     direction  handshake                 payload
//  in             input      in_valid_i / in_stall_o   in_byte_i
//  out            output     out_valid_o / out_stall_i out_byte_o, end_of_string_o
//  capacity       input      out_capacity_we_i         out_capacity_i
//
// One input byte is taken per cycle while in_stall_o is low; its results are
// written into a four-entry result queue that drains one per cycle while
// out_stall_i is low. A terminator may produce two results; the input stalls
// while fewer than two queue slots are free. Reset clears the sequence state,
// the emitted count and the queue, and sets the capacity to 512.
module utf8_to_cp1251_transcoder #(
  parameter int MAX_CAPACITY = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        end_of_string_o,
  input  logic        out_capacity_we_i,
  input  logic [12:0] out_capacity_i
);

  localparam int CfgW = 13;
  localparam int CapW = $clog2(MAX_CAPACITY + 1);
  localparam int CmpW = (CfgW > CapW) ? CfgW : CapW;
  localparam int EmW  = $clog2(MAX_CAPACITY);
  localparam logic [CfgW-1:0] CapReset = CfgW'(512);

  logic [CfgW-1:0]    cap_q;
  logic [CmpW-1:0]    cap_ext, cap_lim, emit_ext;
  logic [EmW-1:0]     emitted_q, emitted_d;
  u2c_pkg::seq_t      seq_q, seq_d;
  u2c_pkg::step_res_t step_res;
  u2c_pkg::res_t      res0, res1, head;
  logic               room, accept, q_full, push0, push1;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (out_capacity_we_i) begin
      cap_q <= out_capacity_i;
    end
  end

  // effective capacity: zero counts as one, large values saturate
  always_comb begin
    cap_ext  = CmpW'(cap_q);
    emit_ext = CmpW'(emitted_q);
    priority if (cap_ext == '0) begin
      cap_lim = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_CAPACITY)) begin
      cap_lim = CmpW'(MAX_CAPACITY);
    end else begin
      cap_lim = cap_ext;
    end
  end

  assign room = (emit_ext + CmpW'(1)) < cap_lim;

  assign accept = in_valid_i && !in_stall_o;

  u2c_step u_step (
    .byte_i (in_byte_i),
    .seq_i  (seq_q),
    .room_i (room),
    .seq_o  (seq_d),
    .res_o  (step_res)
  );

  // emitted character count, cleared by the terminator
  always_comb begin
    emitted_d = emitted_q;
    if (step_res.term) begin
      emitted_d = '0;
    end else if (step_res.char_v) begin
      emitted_d = emitted_q + EmW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= u2c_pkg::SeqClear;
      emitted_q <= '0;
    end else if (accept) begin
      seq_q     <= seq_d;
      emitted_q <= emitted_d;
    end
  end

  // results of this request: character first, then terminator
  assign res0  = '{byte_val: step_res.char_byte, eos: 1'b0};
  assign res1  = '{byte_val: u2c_pkg::ByteTerm, eos: 1'b1};
  assign push0 = accept && step_res.char_v;
  assign push1 = accept && step_res.term;

  u2c_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (res0),
    .data1_i (res1),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .data_o  (head)
  );

  assign in_stall_o      = q_full;
  assign out_byte_o      = head.byte_val;
  assign end_of_string_o = head.eos;

endmodule
